// ----- rtl/etalon_airy_transmission_top_macros.svh -----
// Assertion macros for the etalon transmission block.
// Each expects i_clk and i_rst_n in the scope of the module that uses it.
`ifndef ETALON_AIRY_TRANSMISSION_TOP_MACROS_SVH
`define ETALON_AIRY_TRANSMISSION_TOP_MACROS_SVH

// The condition must never hold outside reset.
`define EAT_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define EAT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/eat_pkg.sv -----
// Shared types, constants and the Taylor divisor table of the etalon block.
// No dependencies.
package eat_pkg;

    localparam int unsigned WL_W    = 24;
    localparam int unsigned OPATH_W = 48;
    localparam int unsigned FCOEF_W = 32;
    localparam int unsigned TR_W    = 17;
    localparam int unsigned N_TERMS = 5;

    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    // Control bits that travel alongside every item in the pipeline.
    typedef struct packed {
        logic valid;
        logic zero;
    } t_ctl;

    // Divisors of the nested Taylor stages, innermost first.
    function automatic int unsigned taylor_div(input int unsigned idx);
        int unsigned k;
        case (idx)
            0: k = 110;
            1: k = 72;
            2: k = 42;
            3: k = 20;
            default: k = 6;
        endcase
        return k;
    endfunction

endpackage

// ----- rtl/eat_if.sv -----
// Stream interfaces of the etalon block: wavelength in, transmission out.
// Depends on nothing.
interface eat_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] wavelength;
    modport source (output valid, output wavelength, input ready);
    modport sink   (input valid, input wavelength, output ready);
endinterface

interface eat_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] transmission;
    logic        zero_wavelength;
    modport source (output valid, output transmission, output zero_wavelength, input ready);
    modport sink   (input valid, input transmission, input zero_wavelength, output ready);
endinterface

// ----- rtl/eat_div_cell.sv -----
// One restoring division step with its pipeline register.
// Depends on eat_pkg for the control struct.
module eat_div_cell #(
    parameter int unsigned DW = 24,
    parameter int unsigned NW = 64,
    parameter int unsigned QW = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  eat_pkg::t_ctl   i_ctl,
    input  logic [DW-1:0]   i_rem,
    input  logic [DW-1:0]   i_div,
    input  logic [NW-1:0]   i_num,
    input  logic [QW-1:0]   i_quo,
    output eat_pkg::t_ctl   o_ctl,
    output logic [DW-1:0]   o_rem,
    output logic [DW-1:0]   o_div,
    output logic [NW-1:0]   o_num,
    output logic [QW-1:0]   o_quo
);

    logic [DW:0]   trial;
    logic          fits;
    logic [DW-1:0] n_rem;
    eat_pkg::t_ctl r_ctl;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;
    logic [NW-1:0] r_num;
    logic [QW-1:0] r_quo;

    // The next dividend bit enters the partial remainder from the top of i_num.
    always_comb begin
        trial = {i_rem, i_num[NW-1]};
        fits  = trial >= {1'b0, i_div};
        n_rem = fits ? DW'(trial - {1'b0, i_div}) : trial[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_div <= i_div;
            r_num <= {i_num[NW-2:0], 1'b0};
            r_quo <= {i_quo[QW-2:0], fits};
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_div = r_div;
    assign o_num = r_num;
    assign o_quo = r_quo;

endmodule

// ----- rtl/eat_taylor_cell.sv -----
// One nested Taylor term of the sine, t' = 1 - ((z2 * t) >> 30) / K, in three stages.
// Depends on eat_pkg for constants and the control struct.
module eat_taylor_cell #(
    parameter int unsigned K = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  eat_pkg::t_ctl i_ctl,
    input  logic [30:0]   i_z,
    input  logic [31:0]   i_z2,
    input  logic [30:0]   i_t,
    output eat_pkg::t_ctl o_ctl,
    output logic [30:0]   o_z,
    output logic [31:0]   o_z2,
    output logic [30:0]   o_t
);

    // Reciprocal of K in Q32; the quotient it gives is at most one short.
    localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(K));

    eat_pkg::t_ctl   r_ctl [3];
    logic [30:0]     r_z   [3];
    logic [31:0]     r_z2  [3];
    logic [31:0]     r_p;
    logic [31:0]     r_pb;
    logic [31:0]     r_q0;
    logic [30:0]     r_t;
    logic [62:0]     prod_a;
    logic [63:0]     prod_b;
    logic [39:0]     qk;
    logic [39:0]     resid;
    logic [32:0]     q;
    logic [30:0]     n_t;

    always_comb begin
        prod_a = 63'(i_z2) * 63'(i_t);
        prod_b = 64'(r_p) * 64'(RECIP);
        qk     = 40'(r_q0) * 40'(K);
        resid  = 40'(r_pb) - qk;
        q      = (resid >= 40'(K)) ? 33'(r_q0) + 33'd1 : 33'(r_q0);
        n_t    = (q >= 33'(eat_pkg::ONE_Q30)) ? '0 : 31'(33'(eat_pkg::ONE_Q30) - q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
            r_ctl[1] <= '0;
            r_ctl[2] <= '0;
        end else if (i_en) begin
            r_ctl[0] <= i_ctl;
            r_ctl[1] <= r_ctl[0];
            r_ctl[2] <= r_ctl[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z[0]  <= i_z;
            r_z[1]  <= r_z[0];
            r_z[2]  <= r_z[1];
            r_z2[0] <= i_z2;
            r_z2[1] <= r_z2[0];
            r_z2[2] <= r_z2[1];
            r_p     <= prod_a[61:30];
            r_pb    <= r_p;
            r_q0    <= prod_b[63:32];
            r_t     <= n_t;
        end
    end

    assign o_ctl = r_ctl[2];
    assign o_z   = r_z[2];
    assign o_z2  = r_z2[2];
    assign o_t   = r_t;

endmodule

// ----- rtl/etalon_airy_transmission_top.sv -----
// Channel   Dir  Payload                          Handshake
// i_in      in   wavelength[23:0]                 valid/ready
// o_out     out  transmission[16:0], zero flag    valid/ready
// apb       in   optical_path, finesse_coefficient  psel/penable, pready high
// One item enters per cycle while the pipeline is not stalled; each item passes through the
// two chains of division cells, the fifteen Taylor stages and the output buffer.
// Reset is synchronous, clears only control state and r_opath, and sets r_fcoef to 32'h0001_0000.
// A two-entry output buffer lets the pipeline run while a result waits; the whole
// pipeline stalls only when that buffer is full and its head is not taken.
// Top level of the etalon transmission block; uses eat_pkg, eat_if, the cells and macros.
`include "etalon_airy_transmission_top_macros.svh"

module etalon_airy_transmission_top #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    eat_in_if.sink            i_in,
    eat_out_if.source         o_out,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [3:0]        i_paddr,
    input  logic [63:0]       i_pwdata,
    output logic [63:0]       o_prdata,
    output logic              o_pready
);

    // Fraction bits beyond sixteen never reach the angle, so the chain stops there.
    localparam int unsigned XB = (FRAC_BITS < 16) ? FRAC_BITS : 16;
    localparam int unsigned N1 = eat_pkg::OPATH_W + XB;
    localparam int unsigned N2 = eat_pkg::TR_W;
    localparam int unsigned NT = eat_pkg::N_TERMS;

    // ---------------- configuration ----------------
    logic [47:0] r_opath;
    logic [31:0] r_fcoef;
    logic        wr;

    assign wr       = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_prdata = i_paddr[3] ? {32'b0, r_fcoef} : {16'b0, r_opath};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opath <= '0;
            r_fcoef <= 32'h0001_0000;
        end else if (wr) begin
            if (i_paddr[3]) begin
                r_fcoef <= i_pwdata[31:0];
            end else begin
                r_opath <= i_pwdata[47:0];
            end
        end
    end

    // ---------------- flow control ----------------
    logic [1:0] r_cnt;
    logic       r_head;
    logic       en;
    logic       push;
    logic       pop;

    assign pop        = o_out.valid && o_out.ready;
    assign en         = (r_cnt != 2'd2) || pop;
    assign i_in.ready = en;

    // ---------------- phase division ----------------
    eat_pkg::t_ctl      c1   [N1+1];
    logic [N1:0][23:0]  rem1;
    logic [N1:0][23:0]  div1;
    logic [N1:0][N1-1:0] num1;
    logic [N1:0][XB-1:0] quo1;

    assign c1[0]   = '{valid: i_in.valid, zero: (i_in.wavelength == '0)};
    assign rem1[0] = '0;
    assign div1[0] = i_in.wavelength;
    assign num1[0] = {r_opath, XB'(0)};
    assign quo1[0] = '0;

    for (genvar g = 0; g < N1; g++) begin : g_div1
        eat_div_cell #(.DW(24), .NW(N1), .QW(XB)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_ctl(c1[g]), .i_rem(rem1[g]), .i_div(div1[g]),
            .i_num(num1[g]), .i_quo(quo1[g]),
            .o_ctl(c1[g+1]), .o_rem(rem1[g+1]), .o_div(div1[g+1]),
            .o_num(num1[g+1]), .o_quo(quo1[g+1])
        );
    end

    // ---------------- angle and its square ----------------
    logic [15:0]   x;
    logic [15:0]   n_y;
    logic [47:0]   prod_z;
    logic [61:0]   prod_z2;
    eat_pkg::t_ctl r_ctl_y, r_ctl_z, r_ctl_z2;
    logic [15:0]   r_y;
    logic [30:0]   r_z, r_z_b;
    logic [31:0]   r_z2;

    always_comb begin
        x       = 16'({quo1[N1], 16'b0} >> XB);
        n_y     = (x <= 16'd32768) ? x : 16'(17'h10000 - 17'(x));
        prod_z  = 48'(eat_pkg::PI_Q30) * 48'(r_y);
        prod_z2 = 62'(r_z) * 62'(r_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_y  <= '0;
            r_ctl_z  <= '0;
            r_ctl_z2 <= '0;
        end else if (en) begin
            r_ctl_y  <= c1[N1];
            r_ctl_z  <= r_ctl_y;
            r_ctl_z2 <= r_ctl_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_y   <= n_y;
            r_z   <= prod_z[46:16];
            r_z_b <= r_z;
            r_z2  <= prod_z2[61:30];
        end
    end

    // ---------------- Taylor chain ----------------
    eat_pkg::t_ctl ct [NT+1];
    logic [NT:0][30:0] zt;
    logic [NT:0][31:0] z2t;
    logic [NT:0][30:0] tt;

    assign ct[0]  = r_ctl_z2;
    assign zt[0]  = r_z_b;
    assign z2t[0] = r_z2;
    assign tt[0]  = eat_pkg::ONE_Q30;

    for (genvar g = 0; g < NT; g++) begin : g_taylor
        eat_taylor_cell #(.K(eat_pkg::taylor_div(g))) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_ctl(ct[g]), .i_z(zt[g]), .i_z2(z2t[g]), .i_t(tt[g]),
            .o_ctl(ct[g+1]), .o_z(zt[g+1]), .o_z2(z2t[g+1]), .o_t(tt[g+1])
        );
    end

    // ---------------- sine, square and denominator ----------------
    logic [61:0]   prod_s;
    logic [61:0]   prod_s2;
    logic [63:0]   prod_den;
    logic [30:0]   n_s;
    eat_pkg::t_ctl r_ctl_s, r_ctl_s2, r_ctl_den;
    logic [30:0]   r_s, r_s2;
    logic [63:0]   r_den;
    logic [63:0]   numer;

    always_comb begin
        prod_s   = 62'(zt[NT]) * 62'(tt[NT]);
        n_s      = (prod_s[61:30] > 32'(eat_pkg::ONE_Q30)) ? eat_pkg::ONE_Q30
                                                           : prod_s[60:30];
        prod_s2  = 62'(r_s) * 62'(r_s);
        prod_den = 64'(r_fcoef) * 64'(r_s2);
        // Rounded quotient: the dividend carries half the divisor.
        numer    = 64'h4000_0000_0000_0000 + (r_den >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_s   <= '0;
            r_ctl_s2  <= '0;
            r_ctl_den <= '0;
        end else if (en) begin
            r_ctl_s   <= ct[NT];
            r_ctl_s2  <= r_ctl_s;
            r_ctl_den <= r_ctl_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s   <= n_s;
            r_s2  <= prod_s2[60:30];
            r_den <= 64'h0000_4000_0000_0000 + prod_den;
        end
    end

    // ---------------- reciprocal division ----------------
    eat_pkg::t_ctl      c2   [N2+1];
    logic [N2:0][63:0]  rem2;
    logic [N2:0][63:0]  div2;
    logic [N2:0][N2-1:0] num2;
    logic [N2:0][N2-1:0] quo2;

    // The quotient is below 2^17, so the top bits already sit below the divisor.
    assign c2[0]   = r_ctl_den;
    assign rem2[0] = 64'(numer[63:N2]);
    assign div2[0] = r_den;
    assign num2[0] = numer[N2-1:0];
    assign quo2[0] = '0;

    for (genvar g = 0; g < N2; g++) begin : g_div2
        eat_div_cell #(.DW(64), .NW(N2), .QW(N2)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_ctl(c2[g]), .i_rem(rem2[g]), .i_div(div2[g]),
            .i_num(num2[g]), .i_quo(quo2[g]),
            .o_ctl(c2[g+1]), .o_rem(rem2[g+1]), .o_div(div2[g+1]),
            .o_num(num2[g+1]), .o_quo(quo2[g+1])
        );
    end

    // ---------------- output buffer ----------------
    logic [16:0] r_buf_tr [2];
    logic        r_buf_z  [2];
    logic        tail;
    logic [1:0]  n_cnt;

    assign push = c2[N2].valid && en;
    assign tail = r_head ^ r_cnt[0];
    assign n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_head <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (pop) begin
                r_head <= !r_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf_tr[tail] <= c2[N2].zero ? '0 : quo2[N2];
            r_buf_z[tail]  <= c2[N2].zero;
        end
    end

    assign o_out.valid           = (r_cnt != 2'd0);
    assign o_out.transmission    = r_buf_tr[r_head];
    assign o_out.zero_wavelength = r_buf_z[r_head];

    // ---------------- checks ----------------
    `EAT_ASSERT_NEVER(a_cnt_range, r_cnt == 2'd3, "output buffer count out of range")
    `EAT_ASSERT_NEVER(a_no_overflow, push && (r_cnt == 2'd2) && !pop, "push into full buffer")
    `EAT_ASSERT_IMPL(a_zero_tr, o_out.valid && o_out.zero_wavelength, o_out.transmission == '0, "zero wavelength gives non-zero transmission")
    `EAT_ASSERT_IMPL(a_tr_max, o_out.valid && o_out.transmission[16], o_out.transmission[15:0] == '0, "transmission above one")

endmodule

// ----- sim/eat_checker.sv -----
// Checker for the etalon transmission block: follows the register port and both streams,
// predicts each transmission and compares it with what comes out. Depends on eat_pkg, eat_if.
module eat_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    eat_in_if           in_ch,
    eat_out_if          out_ch,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [63:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count,
    output int          o_zero_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAC    = 16;
    localparam int unsigned WL_W    = eat_pkg::WL_W;
    localparam int unsigned OPATH_W = eat_pkg::OPATH_W;
    localparam int unsigned FCOEF_W = eat_pkg::FCOEF_W;
    localparam int unsigned TR_W    = eat_pkg::TR_W;
    localparam logic [3:0] ADDR_OPATH = 4'd0;
    localparam logic [3:0] ADDR_FCOEF = 4'd8;

    typedef struct packed {
        logic [TR_W-1:0] transmission;
        logic            zero;
    } t_airy;

    logic [OPATH_W-1:0] opath_q;
    logic [FCOEF_W-1:0] fcoef_q;
    t_airy              airy_q[$];

    function automatic logic [63:0] nested_term(input logic [63:0] z2, input logic [63:0] t,
                                                input logic [63:0] k);
        logic [63:0] p;
        p = ((z2 * t) >> 30) / k;
        return (p >= 64'(eat_pkg::ONE_Q30)) ? 64'd0 : 64'(eat_pkg::ONE_Q30) - p;
    endfunction

    function automatic t_airy airy_transmission(input logic [OPATH_W-1:0] opath,
                                                input logic [FCOEF_W-1:0] fcoef,
                                                input logic [WL_W-1:0] wl);
        t_airy res;
        logic [63:0] r, f, x, y, z, z2, t, s, s2, den;
        res = '0;
        if (wl == '0) begin
            res.zero = 1'b1;
            return res;
        end
        r = 64'(opath) % 64'(wl);
        f = (r << FRAC) / 64'(wl);
        x = (f >> (FRAC - 16)) & 64'hFFFF;
        y = (x <= 64'd32768) ? x : 64'd65536 - x;
        z = (64'(eat_pkg::PI_Q30) * y) >> 16;
        z2 = (z * z) >> 30;
        // Horner form of the sine series, innermost divisor first.
        t = nested_term(z2, 64'(eat_pkg::ONE_Q30), 64'd110);
        t = nested_term(z2, t, 64'd72);
        t = nested_term(z2, t, 64'd42);
        t = nested_term(z2, t, 64'd20);
        t = nested_term(z2, t, 64'd6);
        s = (z * t) >> 30;
        if (s > 64'(eat_pkg::ONE_Q30)) s = 64'(eat_pkg::ONE_Q30);
        s2 = (s * s) >> 30;
        den = (64'd1 << 46) + 64'(fcoef) * s2;
        res.transmission = TR_W'(((64'd1 << 62) + den / 2) / den);
        return res;
    endfunction

    assign o_pending = airy_q.size();

    always @(posedge i_clk) begin
        t_airy exp_r;
        if (!i_rst_n) begin
            opath_q <= '0;
            fcoef_q <= FCOEF_W'(65536);
            airy_q.delete();
            o_fail_count <= 0;
            o_result_count <= 0;
            o_zero_count <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == ADDR_OPATH) opath_q <= i_pwdata[OPATH_W-1:0];
                else if (i_paddr == ADDR_FCOEF) fcoef_q <= i_pwdata[FCOEF_W-1:0];
            end
            if (in_ch.valid && in_ch.ready) begin
                airy_q.insert(airy_q.size(),
                              airy_transmission(opath_q, fcoef_q, in_ch.wavelength));
                if (in_ch.wavelength == '0) o_zero_count <= o_zero_count + 1;
            end
            if (out_ch.valid && out_ch.ready) begin
                o_result_count <= o_result_count + 1;
                if (airy_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%t: unexpected result tr=%0d zero=%0b", $realtime,
                                 out_ch.transmission, out_ch.zero_wavelength);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = airy_q.pop_front();
                    if (exp_r.transmission !== out_ch.transmission ||
                        exp_r.zero !== out_ch.zero_wavelength) begin
                        if (o_fail_count < 10)
                            $display("%t: mismatch expected tr=%0d zero=%0b, got tr=%0d zero=%0b",
                                     $realtime, exp_r.transmission, exp_r.zero,
                                     out_ch.transmission, out_ch.zero_wavelength);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- sim/etalon_airy_transmission_top_tb.sv -----
// Testbench top of the etalon transmission block: clock, reset, register writes and stimulus
// with varied idling; checking is left to eat_checker. Depends on eat_pkg, eat_if, eat_checker.
module etalon_airy_transmission_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WL_W = eat_pkg::WL_W;
    localparam logic [3:0] ADDR_OPATH = 4'd0;
    localparam logic [3:0] ADDR_FCOEF = 4'd8;
    localparam int DRAIN_CYCLES = 150;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    t_idle       idle_mode;
    logic        hold_req;
    int          fail_count, pending, result_count, zero_count;
    int          sent_count;

    eat_in_if  in_ch();
    eat_out_if out_ch();

    etalon_airy_transmission_top DUT (
        .i_clk(clk), .i_rst_n(rst_n), .i_in(in_ch), .o_out(out_ch),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .o_prdata(prdata), .o_pready(pready)
    );

    eat_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready), .o_fail_count(fail_count),
        .o_pending(pending), .o_result_count(result_count), .o_zero_count(zero_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5ms;
        $display("Timeout with %0d results outstanding", pending);
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: stalls by idle mode; a hold request keeps ready low for a long stretch.
    initial begin
        int hold_cnt;
        hold_cnt = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && hold_cnt == 0) begin
                hold_cnt = 400;
                hold_req = 1'b0;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_ch.ready = 1'b0;
            end else if (idle_mode == IDLE_RECEIVER) begin
                out_ch.ready = ($urandom_range(99) >= 85);
            end else if (idle_mode == IDLE_BOTH) begin
                out_ch.ready = ($urandom_range(99) >= 14);
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    task automatic reg_write(input logic [3:0] addr, input logic [63:0] data);
        @(negedge clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = addr; pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_wavelength(input logic [WL_W-1:0] wl);
        int pct;
        pct = (idle_mode == IDLE_SENDER) ? 85 : (idle_mode == IDLE_BOTH) ? 14 : 0;
        while ($urandom_range(99) < pct) begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.wavelength = wl;
        do @(posedge clk); while (!in_ch.ready);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic drain;
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [WL_W-1:0] pick_wavelength();
        int sel;
        sel = $urandom_range(99);
        if (sel < 3) return '0;
        if (sel < 50) return WL_W'($urandom);
        if (sel < 75) return WL_W'($urandom_range(4095, 1));
        return WL_W'($urandom_range(900000, 300000));
    endfunction

    initial begin
        logic [63:0] opath_set[5];
        logic [63:0] fcoef_set[5];
        logic [WL_W-1:0] corner[12];
        int n_items;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_ch.valid = 1'b0; in_ch.wavelength = '0;
        idle_mode = IDLE_NONE; hold_req = 1'b0; sent_count = 0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        corner = '{24'd0, 24'd1, 24'hFFFFFF, 24'hAAAAAA, 24'h555555, 24'd2,
                   24'd3, 24'd632800, 24'd1000000, 24'h800000, 24'h7FFFFF, 24'd4};
        // Reset registers: zero optical path gives full transmission.
        foreach (corner[i]) send_wavelength(corner[i]);
        drain();

        opath_set = '{64'hFFFF_FFFF_FFFF, 64'd0, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF,
                      64'd20000000000, {16'd0, 16'($urandom_range(65535)), $urandom}};
        fcoef_set = '{64'hFFFF_FFFF, 64'd0, 64'(65536 * 100), 64'($urandom), 64'd1};

        for (int ph = 0; ph < 5; ph++) begin
            reg_write(ADDR_OPATH, opath_set[ph]);
            reg_write(ADDR_FCOEF, fcoef_set[ph]);
            idle_mode = t_idle'(ph % 4);
            n_items = 70;
            // The long hold outlasts the pipeline depth, so the input stalls as well.
            if (ph == 0) begin
                hold_req = 1'b1;
                foreach (corner[i]) send_wavelength(corner[i]);
                n_items = 120;
            end
            for (int n = 0; n < n_items; n++) begin
                send_wavelength(pick_wavelength());
            end
            drain();
        end

        $display("Sent %0d wavelengths (%0d zero) over five register settings, %0d results checked",
                 sent_count, zero_count, result_count);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results missing", fail_count, pending);
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
